FILE: hw/rtl/dd_pkg.sv
package dd_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned DNUM_W  = 23;
	localparam int unsigned SPAN_W  = 22;

	localparam logic [14:0] YEAR_SHIFT = 15'd400;
	localparam logic [12:0] RECIP25    = 13'd5243;
	localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD_A = 2'd1,
		ST_BAD_B = 2'd2
	} status_t;

	typedef struct packed {
		logic              ok;
		logic [DNUM_W-1:0] dnum;
	} date_res_t;

	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [8:0] c;
		unique case (m)
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			4'd13, 4'd14, 4'd15: c = 9'd365;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/dd_date_unit.sv
module dd_date_unit (
	input  logic                       clk,
	input  logic [dd_pkg::DAY_W-1:0]   day,
	input  logic [dd_pkg::MONTH_W-1:0] month,
	input  logic [dd_pkg::YEAR_W-1:0]  year,
	output dd_pkg::date_res_t          res
);
	import dd_pkg::*;

	// stage 1: constant multiplies
	logic [14:0] ys, p;
	logic [25:0] prod_p;
	logic [26:0] prod_y;
	logic [23:0] m365;

	logic [DAY_W-1:0]   day_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [12:0]        q4_s1;
	logic [7:0]         qp_s1;
	logic [9:0]         qy_s1;
	logic [DNUM_W-1:0]  m365_s1;

	always_comb begin
		ys     = 15'(year) + YEAR_SHIFT;
		p      = ys - 15'd1;
		prod_p = 26'(p[14:2]) * 26'(RECIP25);
		prod_y = 27'(year) * 27'(RECIP25);
		m365   = 24'(ys) * 24'd365;
	end

	always_ff @(posedge clk) begin
		day_s1   <= day;
		month_s1 <= month;
		year_s1  <= year;
		q4_s1    <= p[14:2];
		qp_s1    <= prod_p[24:17];
		qy_s1    <= prod_y[26:17];
		m365_s1  <= m365[DNUM_W-1:0];
	end

	// stage 2: leap rule, validity, year base
	logic [YEAR_W-1:0] ry;
	logic              leap;
	logic [4:0]        lim;
	logic              ok;
	logic [DNUM_W-1:0] base;

	logic              ok_s2;
	logic [DNUM_W-1:0] base_s2;
	logic [8:0]        cum_s2;
	logic              adj_s2;
	logic [DAY_W-1:0]  day_s2;

	always_comb begin
		ry   = year_s1 - (14'(qy_s1) * 14'd25);
		leap = (year_s1[1:0] == 2'd0) && ((ry != '0) || (year_s1[3:0] == 4'd0));
		lim  = month_len(month_s1, leap);
		ok   = (month_s1 >= 4'd1) && (month_s1 <= 4'd12) && (day_s1 != '0) && (day_s1 <= lim);
		base = m365_s1 + DNUM_W'(q4_s1) - DNUM_W'(qp_s1) + DNUM_W'(qp_s1[7:2]);
	end

	always_ff @(posedge clk) begin
		ok_s2   <= ok;
		base_s2 <= base;
		cum_s2  <= cum_days(month_s1);
		adj_s2  <= leap && (month_s1 > 4'd2);
		day_s2  <= day_s1;
	end

	// stage 3: day number
	date_res_t res_s3;

	always_ff @(posedge clk) begin
		res_s3.ok   <= ok_s2;
		res_s3.dnum <= base_s2 + DNUM_W'(cum_s2) + DNUM_W'(adj_s2) + DNUM_W'(day_s2);
	end

	assign res = res_s3;

endmodule

FILE: hw/rtl/date_difference_days.sv
// Gregorian date difference. Each request carries two dates (day, month,
// year); both are checked and, when valid, the absolute number of days
// between them appears on day_span with status 0. Status 1 flags an invalid
// first date, 2 an invalid second date, and day_span is then 0. Years are
// proleptic Gregorian, year 0 a leap year; spans beyond 22 bits saturate.
// busy is always low: a request is taken every cycle, and its result shows
// on status/day_span for exactly one cycle with done high. The receiver
// cannot stall and must take each result as it appears.
module date_difference_days (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [dd_pkg::DAY_W-1:0]   day_a,
	input  logic [dd_pkg::MONTH_W-1:0] month_a,
	input  logic [dd_pkg::YEAR_W-1:0]  year_a,
	input  logic [dd_pkg::DAY_W-1:0]   day_b,
	input  logic [dd_pkg::MONTH_W-1:0] month_b,
	input  logic [dd_pkg::YEAR_W-1:0]  year_b,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [dd_pkg::SPAN_W-1:0]  day_span
);
	import dd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	date_res_t res_a, res_b;

	dd_date_unit u_date_a (
		.clk   (clk),
		.day   (day_a),
		.month (month_a),
		.year  (year_a),
		.res   (res_a)
	);

	dd_date_unit u_date_b (
		.clk   (clk),
		.day   (day_b),
		.month (month_b),
		.year  (year_b),
		.res   (res_b)
	);

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 4: absolute difference, saturate, status
	logic [DNUM_W-1:0] diff;
	logic [SPAN_W-1:0] span;
	status_t           st;

	status_t           status_s4;
	logic [SPAN_W-1:0] span_s4;

	always_comb begin
		diff = (res_a.dnum >= res_b.dnum) ? (res_a.dnum - res_b.dnum)
		                                  : (res_b.dnum - res_a.dnum);
		span = (diff > DNUM_W'(SPAN_MAX)) ? SPAN_MAX : diff[SPAN_W-1:0];
		priority if (!res_a.ok) begin
			st = ST_BAD_A;
		end else if (!res_b.ok) begin
			st = ST_BAD_B;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		status_s4 <= st;
		span_s4   <= (st == ST_OK) ? span : '0;
	end

	assign done     = v_s4;
	assign status   = status_s4;
	assign day_span = span_s4;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result missing four cycles after request");

	a_zero_span: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (day_span == '0))
		else $error("nonzero span with failing status");

	a_day0: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (day_a == '0)) |-> ##4 (status == ST_BAD_A))
		else $error("day zero in first date not flagged");

endmodule

FILE: tb/date_difference_days_tb.sv
`timescale 1ns / 100ps

module date_difference_days_tb;

	import dd_pkg::*;

	typedef struct {
		status_t              st;
		logic [SPAN_W-1:0]    span;
	} span_due_t;

	class date_span_board;
		span_due_t spans_due[$];
		int n_ok, n_bad_a, n_bad_b, n_sat;

		static function bit is_leap(input int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		static function int unsigned month_days(input int unsigned m, input int unsigned y);
			case (m)
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11:           return 30;
				2:                     return is_leap(y) ? 29 : 28;
				default:               return 0;
			endcase
		endfunction

		static function bit date_ok(input int unsigned d, input int unsigned m,
			input int unsigned y);
			return (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_days(m, y));
		endfunction

		// serial day count from a fixed epoch; year shifted so all terms stay positive
		static function int unsigned day_index(input int unsigned d, input int unsigned m,
			input int unsigned y);
			int unsigned ys, p, n;
			ys = y + 400;
			p = ys - 1;
			n = 365 * ys + p / 4 - p / 100 + p / 400;
			for (int unsigned i = 1; i < m; i++)
				n += month_days(i, 1);
			if (m > 2 && is_leap(y))
				n += 1;
			return n + d;
		endfunction

		function void note_request(input int unsigned da, input int unsigned ma,
			input int unsigned ya, input int unsigned db, input int unsigned mb,
			input int unsigned yb);
			span_due_t e;
			int unsigned na, nb, diff;
			e.span = '0;
			if (!date_ok(da, ma, ya)) begin
				e.st = ST_BAD_A;
				n_bad_a++;
			end else if (!date_ok(db, mb, yb)) begin
				e.st = ST_BAD_B;
				n_bad_b++;
			end else begin
				e.st = ST_OK;
				n_ok++;
				na = day_index(da, ma, ya);
				nb = day_index(db, mb, yb);
				diff = (na >= nb) ? na - nb : nb - na;
				if (diff > SPAN_MAX) begin
					diff = SPAN_MAX;
					n_sat++;
				end
				e.span = diff[SPAN_W-1:0];
			end
			spans_due.push_back(e);
		endfunction

		function bit check_result(input logic [1:0] st, input logic [SPAN_W-1:0] span,
			output string msg);
			span_due_t e;
			msg = "";
			if (spans_due.size() == 0) begin
				msg = $sformatf("result with no request pending: status=%0d day_span=%0d",
					st, span);
				return 0;
			end
			e = spans_due.pop_front();
			if (st !== e.st)
				msg = $sformatf("status got %0d want %0d", st, e.st);
			if (span !== e.span)
				msg = {msg, $sformatf(" day_span got %0d want %0d", span, e.span)};
			return msg == "";
		endfunction

		function int pending();
			return spans_due.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [DAY_W-1:0]    day_a, day_b;
	logic [MONTH_W-1:0]  month_a, month_b;
	logic [YEAR_W-1:0]   year_a, year_b;
	logic                done;
	logic [1:0]          status;
	logic [SPAN_W-1:0]   day_span;

	date_span_board board;
	int n_errors;
	int n_results;

	date_difference_days DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.day_a    (day_a),
		.month_a  (month_a),
		.year_a   (year_a),
		.day_b    (day_b),
		.month_b  (month_b),
		.year_b   (year_b),
		.done     (done),
		.status   (status),
		.day_span (day_span)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		n_errors++;
	endtask

	task automatic send_dates(input int unsigned da, input int unsigned ma,
		input int unsigned ya, input int unsigned db, input int unsigned mb,
		input int unsigned yb);
		@(negedge clk);
		start   = 1'b1;
		day_a   = da[DAY_W-1:0];
		month_a = ma[MONTH_W-1:0];
		year_a  = ya[YEAR_W-1:0];
		day_b   = db[DAY_W-1:0];
		month_b = mb[MONTH_W-1:0];
		year_b  = yb[YEAR_W-1:0];
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		board.note_request(day_a, month_a, year_a, day_b, month_b, year_b);
	endtask

	task automatic idle_cycles(input int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed dates, some at month ends, some raw field noise
	task automatic pick_date(input int unsigned near_y, output int unsigned d,
		output int unsigned m, output int unsigned y);
		int unsigned mode;
		mode = $urandom_range(0, 99);
		if (mode < 80) begin
			if (mode < 10)
				y = (near_y > 20) ? near_y - 20 + $urandom_range(0, 40) : $urandom_range(0, 40);
			else if (mode < 68)
				y = $urandom_range(1, 9999);
			else
				y = $urandom_range(0, (1 << YEAR_W) - 1);
			y = y & ((1 << YEAR_W) - 1);
			m = $urandom_range(1, 12);
			if ($urandom_range(0, 4) == 0)
				d = date_span_board::month_days(m, y);
			else
				d = $urandom_range(1, date_span_board::month_days(m, y));
		end else begin
			d = $urandom_range(0, 31);
			m = $urandom_range(0, 15);
			y = $urandom_range(0, (1 << YEAR_W) - 1);
		end
	endtask

	always @(posedge clk) begin : result_mon
		string note;
		if (arst_n && done) begin
			n_results++;
			if (!board.check_result(status, day_span, note))
				report_mismatch(note);
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned da, ma, ya, db, mb, yb;
		int waited;
		board = new();
		n_errors = 0;
		n_results = 0;
		arst_n  = 1'b0;
		start   = 1'b0;
		day_a   = '0;
		month_a = '0;
		year_a  = '0;
		day_b   = '0;
		month_b = '0;
		year_b  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: range ends, leap rules, invalid fields, saturation
		send_dates(1, 1, 1, 31, 12, 9999);
		send_dates(31, 12, 9999, 1, 1, 1);
		send_dates(15, 6, 2020, 15, 6, 2020);
		send_dates(29, 2, 2000, 1, 3, 2000);
		send_dates(29, 2, 1900, 1, 1, 1900);
		send_dates(28, 2, 1900, 29, 2, 2024);
		send_dates(1, 1, 2024, 30, 2, 2024);
		send_dates(0, 5, 2020, 1, 1, 2020);
		send_dates(1, 0, 2020, 1, 1, 2020);
		send_dates(1, 13, 2020, 1, 1, 2020);
		send_dates(31, 15, 16383, 31, 15, 16383);
		send_dates(1, 1, 2020, 31, 4, 2020);
		send_dates(29, 2, 0, 1, 3, 0);
		send_dates(29, 2, 0, 31, 12, 16383);
		send_dates(1, 1, 16383, 1, 1, 5000);
		send_dates(31, 12, 16383, 1, 1, 4900);
		send_dates(1, 1, 2000, 29, 2, 2100);
		send_dates(31, 1, 2023, 1, 2, 2023);
		send_dates(30, 11, 1999, 31, 12, 1999);
		send_dates(1, 14, 1, 0, 0, 0);
		send_dates(1, 1, 1, 1, 12, 0);
		send_dates(31, 7, 8191, 31, 8, 8192);
		send_dates(16, 10, 10922, 21, 5, 5461);

		for (int k = 0; k < 1150; k++) begin
			if (k == 575)
				drain();
			if (k < 1000 && $urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 16));
			pick_date(0, da, ma, ya);
			pick_date(ya, db, mb, yb);
			if ($urandom_range(0, 49) == 0) begin
				db = da;
				mb = ma;
				yb = ya;
			end
			send_dates(da, ma, ya, db, mb, yb);
		end

		@(negedge clk);
		start = 1'b0;
		waited = 0;
		while (board.pending() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (board.pending() != 0)
			report_mismatch($sformatf("%0d requests never answered", board.pending()));

		$display("Covered %0d results: %0d valid pairs (%0d saturated),",
			n_results, board.n_ok, board.n_sat);
		$display("%0d bad first, %0d bad second; mismatches: %0d",
			board.n_bad_a, board.n_bad_b, n_errors);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
